@@ design/dcof_pkg.sv @@
package dcof_pkg;

  localparam int PIVOT_DEPTH = 256;
  localparam int PIVOT_AW    = $clog2(PIVOT_DEPTH);
  localparam int CODE_BITS   = 20;
  localparam int CNT_W       = 9;
  localparam int FRAC_W      = 24;

  localparam logic [3:0] PFX_WRITE   = 4'b0001;
  localparam logic [3:0] PFX_CONTROL = 4'b0010;
  localparam logic [3:0] PFX_CLEAR   = 4'b0011;

  typedef enum logic [1:0] {
    CMD_PIVOT   = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_CONTROL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RANGE_UNI5  = 2'd0,
    RANGE_UNI10 = 2'd1,
    RANGE_BI5   = 2'd2,
    RANGE_BI10  = 2'd3
  } range_e;

  typedef enum logic [2:0] {
    REG_RANGE_SELECT = 3'd0,
    REG_INVERT       = 3'd1,
    REG_LIMIT_LOW    = 3'd2,
    REG_LIMIT_HIGH   = 3'd3,
    REG_CAL_ENABLE   = 3'd4,
    REG_CAL_MIN      = 3'd5,
    REG_CAL_SCALE    = 3'd6,
    REG_PIVOT_COUNT  = 3'd7
  } cfg_reg_e;

  // Sideband that travels with every item down the pipeline.
  typedef struct packed {
    logic        vld;
    cmd_e        cmd;
    logic [31:0] data;
  } tag_t;

  // Zero voltage of each output range, Q8.24.
  function automatic logic signed [31:0] zero_volt(range_e rng);
    case (rng)
      RANGE_UNI5:  zero_volt = 32'sd41943040;
      RANGE_UNI10: zero_volt = 32'sd83886080;
      default:     zero_volt = 32'sd0;
    endcase
  endfunction

  // Half of the scaling denominator, span * 2^24.
  function automatic logic [31:0] half_den(range_e rng);
    case (rng)
      RANGE_UNI5:  half_den = 32'd83886080;
      RANGE_BI10:  half_den = 32'd335544320;
      default:     half_den = 32'd167772160;
    endcase
  endfunction

  // The denominator is 5 * 2^k; this returns k.
  function automatic logic [4:0] den_shift(range_e rng);
    case (rng)
      RANGE_UNI5:  den_shift = 5'd25;
      RANGE_BI10:  den_shift = 5'd27;
      default:     den_shift = 5'd26;
    endcase
  endfunction

  // Control word with the buffer bit set and the linearity bits of the span.
  function automatic logic [23:0] ctrl_frame(range_e rng);
    case (rng)
      RANGE_UNI5:  ctrl_frame = {PFX_CONTROL, 20'h00002};
      RANGE_BI10:  ctrl_frame = {PFX_CONTROL, 20'h00302};
      default:     ctrl_frame = {PFX_CONTROL, 20'h00242};
    endcase
  endfunction

endpackage

@@ design/dcof_front.sv @@
module dcof_front import dcof_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_vld_i,
  input  cmd_e                    cmd_i,
  input  logic [31:0]             value_i,
  input  logic [7:0]              pidx_i,
  input  logic signed [31:0]      limit_low_i,
  input  logic signed [31:0]      limit_high_i,
  input  logic signed [31:0]      cal_min_i,
  input  logic [31:0]             cal_scale_i,
  input  logic [CNT_W-1:0]        pivot_count_i,
  output tag_t                    tag_o,
  output logic [PIVOT_AW-1:0]     idx_o,
  output logic [FRAC_W:0]         frac_o,
  output logic [7:0]              pidx_o
);

  // Stage 1: clamp to the limits, low limit first.
  logic signed [31:0] val_s, lo_clamp, clamp_v;
  tag_t               s1_tag_d, s1_tag_q;
  logic [7:0]         s1_pidx_q;

  always_comb begin
    val_s    = signed'(value_i);
    lo_clamp = (val_s < limit_low_i) ? limit_low_i : val_s;
    clamp_v  = (lo_clamp > limit_high_i) ? limit_high_i : lo_clamp;
    s1_tag_d.vld  = in_vld_i;
    s1_tag_d.cmd  = cmd_i;
    s1_tag_d.data = (cmd_i == CMD_WRITE) ? clamp_v : value_i;
  end

  // Stage 2: offset from the first pivot.
  logic signed [32:0] s2_diff_d, s2_diff_q;
  tag_t               s2_tag_q;
  logic [7:0]         s2_pidx_q;

  assign s2_diff_d = $signed({s1_tag_q.data[31], s1_tag_q.data}) -
                     $signed({cal_min_i[31], cal_min_i});

  // Stage 3: fractional pivot index, 40 fraction bits.
  logic        s3_pos_d, s3_pos_q;
  logic [63:0] s3_prod_d, s3_prod_q;
  tag_t        s3_tag_q;
  logic [7:0]  s3_pidx_q;

  assign s3_pos_d  = ~s2_diff_q[32] && (s2_diff_q[31:0] != 32'd0);
  assign s3_prod_d = 64'(s2_diff_q[31:0]) * 64'(cal_scale_i);

  // Stage 4: clamp the index to the pivots in use.
  logic [CNT_W-1:0]    n_eff, nm1, idx_n;
  logic [23:0]         ip;
  logic [FRAC_W:0]     s4_frac_d, s4_frac_q;
  logic [PIVOT_AW-1:0] s4_idx_d, s4_idx_q;
  tag_t                s4_tag_q;
  logic [7:0]          s4_pidx_q;

  always_comb begin
    if (pivot_count_i < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (32'(pivot_count_i) > PIVOT_DEPTH) begin
      n_eff = CNT_W'(PIVOT_DEPTH);
    end else begin
      n_eff = pivot_count_i;
    end
    nm1 = n_eff - CNT_W'(1);
    ip  = s3_prod_q[63:40];
    if (!s3_pos_q) begin
      idx_n     = '0;
      s4_frac_d = '0;
    end else if (ip >= 24'(nm1)) begin
      // Past the top pivot: last interval with fraction one.
      idx_n     = nm1 - CNT_W'(1);
      s4_frac_d = (FRAC_W + 1)'(1) << FRAC_W;
    end else begin
      idx_n     = ip[CNT_W-1:0];
      s4_frac_d = {1'b0, s3_prod_q[39:16]};
    end
    s4_idx_d = PIVOT_AW'(idx_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
      s4_tag_q <= '0;
    end else begin
      s1_tag_q <= s1_tag_d;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
      s4_tag_q <= s3_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pidx_q <= pidx_i;
    s2_pidx_q <= s1_pidx_q;
    s2_diff_q <= s2_diff_d;
    s3_pidx_q <= s2_pidx_q;
    s3_pos_q  <= s3_pos_d;
    s3_prod_q <= s3_prod_d;
    s4_pidx_q <= s3_pidx_q;
    s4_idx_q  <= s4_idx_d;
    s4_frac_q <= s4_frac_d;
  end

  assign tag_o  = s4_tag_q;
  assign idx_o  = s4_idx_q;
  assign frac_o = s4_frac_q;
  assign pidx_o = s4_pidx_q;

endmodule

@@ design/dcof_pivot_stage.sv @@
module dcof_pivot_stage import dcof_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tag_t                tag_i,
  input  logic [PIVOT_AW-1:0] idx_i,
  input  logic [FRAC_W:0]     frac_i,
  input  logic [7:0]          pidx_i,
  output tag_t                tag_o,
  output logic [FRAC_W:0]     frac_o,
  output logic signed [31:0]  p0_o,
  output logic signed [31:0]  p1_o
);

  // Pivot writes and pivot reads happen in this one stage, so every item
  // sees exactly the pivots loaded by the items ahead of it.
  logic [31:0]         pivot_mem [PIVOT_DEPTH];
  logic                we;
  logic [PIVOT_AW-1:0] waddr, ra1;
  logic [31:0]         p0_q, p1_q;
  logic [FRAC_W:0]     frac_q;
  tag_t                tag_q;

  assign we    = tag_i.vld && (tag_i.cmd == CMD_PIVOT) && (32'(pidx_i) < PIVOT_DEPTH);
  assign waddr = PIVOT_AW'(pidx_i);
  assign ra1   = idx_i + PIVOT_AW'(1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      pivot_mem[waddr] <= tag_i.data;
    end
    p0_q   <= pivot_mem[idx_i];
    p1_q   <= pivot_mem[ra1];
    frac_q <= frac_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign tag_o  = tag_q;
  assign frac_o = frac_q;
  assign p0_o   = signed'(p0_q);
  assign p1_o   = signed'(p1_q);

endmodule

@@ design/dcof_interp.sv @@
module dcof_interp import dcof_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tag_t               tag_i,
  input  logic [FRAC_W:0]    frac_i,
  input  logic signed [31:0] p0_i,
  input  logic signed [31:0] p1_i,
  input  logic               cal_enable_i,
  output tag_t               tag_o,
  output logic signed [31:0] target_o
);

  // Stage 6: magnitude and sign of the pivot step.
  logic signed [32:0] d;
  logic [32:0]        s6_mag_d, s6_mag_q;
  logic               s6_neg_q;
  logic signed [31:0] s6_p0_q;
  logic [FRAC_W:0]    s6_frac_q;
  tag_t               s6_tag_q;

  always_comb begin
    d        = $signed({p1_i[31], p1_i}) - $signed({p0_i[31], p0_i});
    s6_mag_d = d[32] ? 33'(-d) : 33'(d);
  end

  // Stage 7: step times fraction.
  logic [57:0]        s7_prod_d, s7_prod_q;
  logic               s7_neg_q;
  logic signed [31:0] s7_p0_q;
  tag_t               s7_tag_q;

  assign s7_prod_d = 58'(s6_mag_q) * 58'(s6_frac_q);

  // Stage 8: a falling step rounds toward minus infinity.
  logic [57:0]        rnd;
  logic [33:0]        tmag;
  logic signed [33:0] p0_x, sum;
  logic signed [31:0] s8_target_d, s8_target_q;
  tag_t               s8_tag_q;

  always_comb begin
    rnd  = s7_prod_q + 58'(24'hFFFFFF);
    tmag = s7_neg_q ? rnd[57:24] : s7_prod_q[57:24];
    p0_x = {{2{s7_p0_q[31]}}, s7_p0_q};
    sum  = s7_neg_q ? (p0_x - $signed(tmag)) : (p0_x + $signed(tmag));
    s8_target_d = cal_enable_i ? sum[31:0] : signed'(s7_tag_q.data);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_tag_q <= '0;
      s7_tag_q <= '0;
      s8_tag_q <= '0;
    end else begin
      s6_tag_q <= tag_i;
      s7_tag_q <= s6_tag_q;
      s8_tag_q <= s7_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_mag_q    <= s6_mag_d;
    s6_neg_q    <= d[32];
    s6_p0_q     <= p0_i;
    s6_frac_q   <= frac_i;
    s7_prod_q   <= s7_prod_d;
    s7_neg_q    <= s6_neg_q;
    s7_p0_q     <= s6_p0_q;
    s8_target_q <= s8_target_d;
  end

  assign tag_o    = s8_tag_q;
  assign target_o = s8_target_q;

endmodule

@@ design/dcof_scale.sv @@
module dcof_scale import dcof_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tag_t               tag_i,
  input  logic signed [31:0] target_i,
  input  range_e             range_i,
  input  logic               invert_i,
  output logic               strobe_o,
  output logic [23:0]        frame_o,
  output logic [31:0]        clamped_o,
  output logic               sat_o
);

  localparam logic signed [30:0] CMAX = 31'((1 <<< (CODE_BITS - 1)) - 1);
  localparam logic signed [30:0] CMIN = 31'(-(1 <<< (CODE_BITS - 1)));

  // Stage 9: offset by the zero voltage of the range.
  logic signed [31:0] zv;
  logic signed [33:0] s9_x_d, s9_x_q;
  tag_t               s9_tag_q;

  always_comb begin
    zv     = zero_volt(range_i);
    s9_x_d = $signed({{2{target_i[31]}}, target_i}) - $signed({{2{zv[31]}}, zv});
  end

  // Stage 10: numerator 2 * x * (2^CODE_BITS - 1) - den / 2.
  logic signed [56:0] xe, s10_num_d, s10_num_q;
  tag_t               s10_tag_q;

  always_comb begin
    xe        = {{23{s9_x_q[33]}}, s9_x_q};
    s10_num_d = (xe <<< (CODE_BITS + 1)) - (xe <<< 1) - $signed({25'd0, half_den(range_i)});
  end

  // Stage 11: magnitude divided by the power-of-two part of the denominator.
  logic [56:0] mag;
  logic [31:0] s11_a_d, s11_a_q;
  logic        s11_neg_q;
  tag_t        s11_tag_q;

  always_comb begin
    mag     = s10_num_q[56] ? 57'(-s10_num_q) : 57'(s10_num_q);
    s11_a_d = 32'(mag >> den_shift(range_i));
  end

  // Stage 12: divide by five through the reciprocal.
  logic [63:0] s12_prod_d, s12_prod_q;
  logic        s12_neg_q;
  tag_t        s12_tag_q;

  assign s12_prod_d = 64'(s11_a_q) * 64'(32'hCCCCCCCD);

  // Stage 13: sign, saturation, inversion and framing.
  logic [29:0]           q;
  logic signed [30:0]    code, code_c;
  logic                  sat;
  logic [CODE_BITS-1:0]  code_w;
  logic [19:0]           data20;
  logic                  strobe_d, strobe_q;
  logic [23:0]           frame_d, frame_q;
  logic [31:0]           clamped_d, clamped_q;
  logic                  sat_d, sat_q;

  always_comb begin
    q    = s12_prod_q[63:34];
    code = s12_neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
    code_c = code;
    sat    = 1'b0;
    if (code > CMAX) begin
      code_c = CMAX;
      sat    = 1'b1;
    end else if (code < CMIN) begin
      code_c = CMIN;
      sat    = 1'b1;
    end
    if (invert_i) begin
      if (code_c == CMIN) begin
        code_c = CMAX;
        sat    = 1'b1;
      end else begin
        code_c = -code_c;
      end
    end
    code_w = code_c[CODE_BITS-1:0];
    data20 = 20'(code_w) << (20 - CODE_BITS);

    strobe_d  = s12_tag_q.vld && (s12_tag_q.cmd != CMD_PIVOT);
    frame_d   = '0;
    clamped_d = '0;
    sat_d     = 1'b0;
    case (s12_tag_q.cmd)
      CMD_WRITE: begin
        frame_d   = {PFX_WRITE, data20};
        clamped_d = s12_tag_q.data;
        sat_d     = sat;
      end
      CMD_CLEAR: begin
        frame_d = {PFX_CLEAR, s12_tag_q.data[19:0]};
      end
      CMD_CONTROL: begin
        frame_d = ctrl_frame(range_i);
      end
      default: begin
        frame_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_tag_q  <= '0;
      s10_tag_q <= '0;
      s11_tag_q <= '0;
      s12_tag_q <= '0;
      strobe_q  <= 1'b0;
    end else begin
      s9_tag_q  <= tag_i;
      s10_tag_q <= s9_tag_q;
      s11_tag_q <= s10_tag_q;
      s12_tag_q <= s11_tag_q;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s9_x_q     <= s9_x_d;
    s10_num_q  <= s10_num_d;
    s11_a_q    <= s11_a_d;
    s11_neg_q  <= s10_num_q[56];
    s12_prod_q <= s12_prod_d;
    s12_neg_q  <= s11_neg_q;
    frame_q    <= frame_d;
    clamped_q  <= clamped_d;
    sat_q      <= sat_d;
  end

  assign strobe_o  = strobe_q;
  assign frame_o   = frame_q;
  assign clamped_o = clamped_q;
  assign sat_o     = sat_q;

endmodule

@@ design/dac_calibrated_output_framer.sv @@
// Frame encoder for a 20-bit serial DAC. The block accepts one command in
// every clock cycle (busy stays low) and is a thirteen-stage pipeline: the
// result of a command is on the result ports, marked by result_strobe_o,
// for exactly one cycle, since the receiver cannot hold results off. Results
// leave in the order the commands came in. Command 0 loads a calibration
// pivot and yields no result; the pivot store is written at the same
// pipeline stage where the interpolation reads it, so any command issued
// after a pivot load sees the new pivot and any command issued before it
// sees the old one. Reading a pivot that was never loaded gives an
// undefined frame. The configuration registers are set through the APB
// port and must only be changed while no command is in flight, i.e.
// thirteen idle cycles after the last command.
module dac_calibrated_output_framer import dcof_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] value_i,
  input  logic [7:0]  pivot_index_i,

  // Result channel.
  output logic        result_strobe_o,
  output logic [23:0] frame_o,
  output logic [31:0] clamped_voltage_o,
  output logic        code_saturated_o,

  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The pipeline never stalls, so a command is taken in every cycle.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration registers.
  range_e             range_q;
  logic               invert_q;
  logic signed [31:0] limit_low_q;
  logic signed [31:0] limit_high_q;
  logic               cal_enable_q;
  logic signed [31:0] cal_min_q;
  logic [31:0]        cal_scale_q;
  logic [CNT_W-1:0]   pivot_count_q;

  logic     cfg_wr;
  cfg_reg_e cfg_sel;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q       <= RANGE_BI10;
      invert_q      <= 1'b0;
      limit_low_q   <= -32'sd167772160;
      limit_high_q  <= 32'sd167772160;
      cal_enable_q  <= 1'b0;
      cal_min_q     <= '0;
      cal_scale_q   <= 32'h0001_0000;
      pivot_count_q <= CNT_W'(2);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_RANGE_SELECT: range_q       <= range_e'(pwdata[1:0]);
        REG_INVERT:       invert_q      <= pwdata[0];
        REG_LIMIT_LOW:    limit_low_q   <= signed'(pwdata);
        REG_LIMIT_HIGH:   limit_high_q  <= signed'(pwdata);
        REG_CAL_ENABLE:   cal_enable_q  <= pwdata[0];
        REG_CAL_MIN:      cal_min_q     <= signed'(pwdata);
        REG_CAL_SCALE:    cal_scale_q   <= pwdata;
        REG_PIVOT_COUNT:  pivot_count_q <= pwdata[CNT_W-1:0];
        default:          range_q       <= range_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_RANGE_SELECT: prdata = 32'(range_q);
      REG_INVERT:       prdata = 32'(invert_q);
      REG_LIMIT_LOW:    prdata = limit_low_q;
      REG_LIMIT_HIGH:   prdata = limit_high_q;
      REG_CAL_ENABLE:   prdata = 32'(cal_enable_q);
      REG_CAL_MIN:      prdata = cal_min_q;
      REG_CAL_SCALE:    prdata = cal_scale_q;
      REG_PIVOT_COUNT:  prdata = 32'(pivot_count_q);
      default:          prdata = '0;
    endcase
  end

  // Stages 1 to 4: clamping, offset, fractional index and index clamp.
  tag_t                fr_tag;
  logic [PIVOT_AW-1:0] fr_idx;
  logic [FRAC_W:0]     fr_frac;
  logic [7:0]          fr_pidx;

  dcof_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_vld_i      (start && !busy),
    .cmd_i         (cmd_e'(command_i)),
    .value_i       (value_i),
    .pidx_i        (pivot_index_i),
    .limit_low_i   (limit_low_q),
    .limit_high_i  (limit_high_q),
    .cal_min_i     (cal_min_q),
    .cal_scale_i   (cal_scale_q),
    .pivot_count_i (pivot_count_q),
    .tag_o         (fr_tag),
    .idx_o         (fr_idx),
    .frac_o        (fr_frac),
    .pidx_o        (fr_pidx)
  );

  // Stage 5: pivot store, written by pivot loads and read for interpolation.
  tag_t               pv_tag;
  logic [FRAC_W:0]    pv_frac;
  logic signed [31:0] pv_p0;
  logic signed [31:0] pv_p1;

  dcof_pivot_stage u_pivot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (fr_tag),
    .idx_i  (fr_idx),
    .frac_i (fr_frac),
    .pidx_i (fr_pidx),
    .tag_o  (pv_tag),
    .frac_o (pv_frac),
    .p0_o   (pv_p0),
    .p1_o   (pv_p1)
  );

  // Stages 6 to 8: linear interpolation between the two pivots.
  tag_t               ip_tag;
  logic signed [31:0] ip_target;

  dcof_interp u_interp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (pv_tag),
    .frac_i       (pv_frac),
    .p0_i         (pv_p0),
    .p1_i         (pv_p1),
    .cal_enable_i (cal_enable_q),
    .tag_o        (ip_tag),
    .target_o     (ip_target)
  );

  // Stages 9 to 13: scaling to a DAC code, saturation and framing.
  dcof_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (ip_tag),
    .target_i  (ip_target),
    .range_i   (range_q),
    .invert_i  (invert_q),
    .strobe_o  (result_strobe_o),
    .frame_o   (frame_o),
    .clamped_o (clamped_voltage_o),
    .sat_o     (code_saturated_o)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the calibrated DAC frame encoder. Commands go in
// through the start/busy handshake, and every frame that comes out is
// checked against a frame predicted inside the bench when its command was
// taken. The configuration registers are changed only between groups of
// commands, once the pipeline has drained.
module tb_top;
  import dcof_pkg::*;

  // Pipeline depth as documented at the head of the block.
  localparam int PIPE_LATENCY = 13;
  // Cycles in a row with no transaction of any kind before the run is abandoned.
  localparam int QUIET_LIMIT  = 1000;
  // One volt in Q8.24.
  localparam longint VOLT     = 64'sd16777216;

  typedef struct packed {
    logic [23:0] frame;
    logic [31:0] clamped;
    logic        saturated;
  } dac_result_t;

  typedef struct {
    range_e      rng;
    logic        invert;
    logic [31:0] lim_lo;
    logic [31:0] lim_hi;
    logic        cal_en;
    logic [31:0] cal_min;
    logic [31:0] cal_scale;
    logic [8:0]  pivots;
  } dac_settings_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic [31:0] value_i;
  logic [7:0]  pivot_index_i;
  logic        result_strobe_o;
  logic [23:0] frame_o;
  logic [31:0] clamped_voltage_o;
  logic        code_saturated_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dac_calibrated_output_framer DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .value_i           (value_i),
    .pivot_index_i     (pivot_index_i),
    .result_strobe_o   (result_strobe_o),
    .frame_o           (frame_o),
    .clamped_voltage_o (clamped_voltage_o),
    .code_saturated_o  (code_saturated_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #2 clk_i = ~clk_i;

  // Copy of the configuration as the bench last wrote it.
  range_e          cfg_range;
  logic            cfg_invert;
  logic            cfg_cal_en;
  longint          cfg_lim_lo;
  longint          cfg_lim_hi;
  longint          cfg_cal_min;
  longint unsigned cfg_cal_scale;
  int unsigned     cfg_pivot_count;

  // Copy of the pivot store. A slot counts as loaded once a pivot command
  // for it has been taken; the block gives no defined output for the rest.
  logic [31:0] pivot_mem [PIVOT_DEPTH];
  bit          pivot_loaded [PIVOT_DEPTH];

  // Frames predicted for commands already taken, oldest first.
  dac_result_t pending_frames[$];

  int error_count     = 0;
  int sender_idle_pct = 0;
  int quiet_cycles    = 0;

  function automatic longint clamp_target(longint v);
    // The low limit goes first, so crossed limits end up at the high one.
    if (v < cfg_lim_lo) v = cfg_lim_lo;
    if (v > cfg_lim_hi) v = cfg_lim_hi;
    return v;
  endfunction

  // Finds the pivot interval for a voltage and the 24-bit fraction within it.
  function automatic void locate_pivot(input longint v, output int unsigned slot,
                                       output longint unsigned frac);
    longint unsigned n;
    longint unsigned prod;
    longint unsigned ip;
    longint          diff;
    n = 64'(cfg_pivot_count);
    if (n < 2) n = 2;
    if (n > PIVOT_DEPTH) n = PIVOT_DEPTH;
    diff = v - cfg_cal_min;
    slot = 0;
    frac = 0;
    if (diff > 0) begin
      // Q8.24 times Q16.16 leaves the whole interval count above bit 40.
      prod = $unsigned(diff) * cfg_cal_scale;
      ip   = prod >> 40;
      if (ip >= n - 1) begin
        // Past the top pivot: the last interval at its far end.
        slot = 32'(n - 2);
        frac = 64'd1 << FRAC_W;
      end else begin
        slot = 32'(ip);
        frac = (prod >> 16) & 64'hFF_FFFF;
      end
    end
  endfunction

  function automatic longint interp_voltage(longint v);
    int unsigned     slot;
    longint unsigned frac;
    longint unsigned mag;
    longint          p0;
    longint          p1;
    longint          d;
    locate_pivot(v, slot, frac);
    p0 = 64'($signed(pivot_mem[slot]));
    p1 = 64'($signed(pivot_mem[slot + 1]));
    d  = p1 - p0;
    if (d >= 0) begin
      mag = ($unsigned(d) * frac) >> FRAC_W;
      return p0 + $signed(mag);
    end
    // A falling segment rounds the step toward minus infinity.
    mag = ($unsigned(-d) * frac + 64'hFF_FFFF) >> FRAC_W;
    return p0 - $signed(mag);
  endfunction

  // Applies one taken command to the bench's copy of the block and queues
  // the frame that it must produce, if any.
  function automatic void encode_command(cmd_e cmd, logic [31:0] val, logic [7:0] idx);
    dac_result_t r;
    longint      v;
    longint      target;
    longint      zero;
    longint      span;
    longint      den;
    longint      num;
    longint      code;
    longint      cmax;
    longint      cmin;
    logic        sat;
    r = '0;
    case (cmd)
      CMD_PIVOT: begin
        pivot_mem[idx]    = val;
        pivot_loaded[idx] = 1'b1;
        return;
      end
      CMD_CLEAR: r.frame = {PFX_CLEAR, val[19:0]};
      CMD_CONTROL: begin
        case (cfg_range)
          RANGE_UNI5: r.frame = {PFX_CONTROL, 20'h00002};
          RANGE_BI10: r.frame = {PFX_CONTROL, 20'h00302};
          default:    r.frame = {PFX_CONTROL, 20'h00242};
        endcase
      end
      default: begin
        v      = clamp_target(64'($signed(val)));
        target = cfg_cal_en ? interp_voltage(v) : v;
        case (cfg_range)
          RANGE_UNI5: begin
            zero = 5 * VOLT / 2;
            span = 5;
          end
          RANGE_UNI10: begin
            zero = 5 * VOLT;
            span = 10;
          end
          RANGE_BI5: begin
            zero = 0;
            span = 10;
          end
          default: begin
            zero = 0;
            span = 20;
          end
        endcase
        // Scale by full code over span, minus one half, truncated toward zero.
        den  = span << 25;
        num  = 2 * (target - zero) * ((64'sd1 << CODE_BITS) - 1) - den / 2;
        code = num / den;
        cmax = (64'sd1 << (CODE_BITS - 1)) - 1;
        cmin = -cmax - 1;
        sat  = 1'b0;
        if (code > cmax) begin
          code = cmax;
          sat  = 1'b1;
        end
        if (code < cmin) begin
          code = cmin;
          sat  = 1'b1;
        end
        if (cfg_invert) begin
          // The most negative code has no positive twin and saturates.
          if (code == cmin) begin
            code = cmax;
            sat  = 1'b1;
          end else begin
            code = -code;
          end
        end
        r.frame     = {PFX_WRITE, code[19:0]};
        r.clamped   = v[31:0];
        r.saturated = sat;
      end
    endcase
    pending_frames.push_back(r);
  endfunction

  // A voltage within about twelve volts of zero, or now and then any word.
  function automatic logic [31:0] pick_volts(int full_pct);
    if ($urandom_range(0, 99) < full_pct) return $urandom;
    return 32'($urandom_range(0, 32'd402653184)) - 32'd201326592;
  endfunction

  // Sends one command and waits until the block takes it. The sender may
  // first idle for a few cycles; start otherwise stays high from one
  // transaction to the next.
  task automatic drive_command(cmd_e cmd, logic [31:0] val, logic [7:0] idx);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    command_i     <= cmd;
    value_i       <= val;
    pivot_index_i <= idx;
    do @(posedge clk_i); while (busy !== 1'b0);
    encode_command(cmd, val, idx);
  endtask

  // Like drive_command, but a voltage that would be interpolated between
  // pivots that were never loaded gets those pivots loaded first.
  task automatic issue_command(cmd_e cmd, logic [31:0] val, logic [7:0] idx);
    int unsigned     slot;
    longint unsigned frac;
    if (cmd == CMD_WRITE && cfg_cal_en) begin
      locate_pivot(clamp_target(64'($signed(val))), slot, frac);
      for (int k = 0; k < 2; k++) begin
        if (!pivot_loaded[slot + k]) drive_command(CMD_PIVOT, pick_volts(10), 8'(slot + k));
      end
    end
    drive_command(cmd, val, idx);
  endtask

  // Stops sending, waits for every outstanding frame, then lets the
  // pipeline run empty, since a pivot load in flight yields no frame.
  task automatic settle_pipeline();
    start <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 3) @(posedge clk_i);
  endtask

  // One APB write: setup, then access until pready. The bus is left
  // selected so that writes can follow back to back.
  task automatic cfg_write(cfg_reg_e r, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (r)
      REG_RANGE_SELECT: cfg_range       = range_e'(data[1:0]);
      REG_INVERT:       cfg_invert      = data[0];
      REG_LIMIT_LOW:    cfg_lim_lo      = 64'($signed(data));
      REG_LIMIT_HIGH:   cfg_lim_hi      = 64'($signed(data));
      REG_CAL_ENABLE:   cfg_cal_en      = data[0];
      REG_CAL_MIN:      cfg_cal_min     = 64'($signed(data));
      REG_CAL_SCALE:    cfg_cal_scale   = 64'(data);
      default:          cfg_pivot_count = 32'(data[8:0]);
    endcase
  endtask

  task automatic program_settings(dac_settings_t s);
    settle_pipeline();
    cfg_write(REG_RANGE_SELECT, 32'(s.rng));
    cfg_write(REG_INVERT, 32'(s.invert));
    cfg_write(REG_LIMIT_LOW, s.lim_lo);
    cfg_write(REG_LIMIT_HIGH, s.lim_hi);
    cfg_write(REG_CAL_ENABLE, 32'(s.cal_en));
    cfg_write(REG_CAL_MIN, s.cal_min);
    cfg_write(REG_CAL_SCALE, s.cal_scale);
    cfg_write(REG_PIVOT_COUNT, 32'(s.pivots));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic dac_settings_t default_settings();
    dac_settings_t s;
    s.rng       = RANGE_BI10;
    s.invert    = 1'b0;
    s.lim_lo    = -32'(10 * VOLT);
    s.lim_hi    = 32'(10 * VOLT);
    s.cal_en    = 1'b0;
    s.cal_min   = '0;
    s.cal_scale = 32'h0001_0000;
    s.pivots    = 9'd2;
    return s;
  endfunction

  // Random settings that hit the extremes of every register now and then.
  function automatic dac_settings_t random_settings();
    dac_settings_t s;
    logic [31:0]   a;
    logic [31:0]   b;
    a = pick_volts(0);
    b = pick_volts(0);
    s.rng    = range_e'($urandom_range(0, 3));
    s.invert = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: begin
        s.lim_lo = 32'h8000_0000;
        s.lim_hi = 32'h7FFF_FFFF;
      end
      1: begin
        // Any two words; the limits may well be crossed.
        s.lim_lo = $urandom;
        s.lim_hi = $urandom;
      end
      default: begin
        s.lim_lo = ($signed(a) < $signed(b)) ? a : b;
        s.lim_hi = ($signed(a) < $signed(b)) ? b : a;
      end
    endcase
    s.cal_en = $urandom_range(0, 99) < 60;
    case ($urandom_range(0, 9))
      0:       s.cal_min = 32'h8000_0000;
      1:       s.cal_min = 32'h7FFF_FFFF;
      default: s.cal_min = -32'($urandom_range(0, 32'd201326592));
    endcase
    case ($urandom_range(0, 9))
      0:       s.cal_scale = '0;
      1:       s.cal_scale = 32'hFFFF_FFFF;
      2:       s.cal_scale = $urandom;
      default: s.cal_scale = {16'($urandom_range(0, 40)), 16'($urandom)};
    endcase
    case ($urandom_range(0, 9))
      0:       s.pivots = 9'($urandom_range(0, 1));
      1:       s.pivots = 9'($urandom_range(257, 511));
      default: s.pivots = 9'($urandom_range(2, 256));
    endcase
    return s;
  endfunction

  task automatic random_command();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) issue_command(CMD_PIVOT, pick_volts(10), 8'($urandom));
    else if (pick < 70) issue_command(CMD_WRITE, pick_volts(15), 8'($urandom));
    else if (pick < 85) issue_command(CMD_CLEAR, $urandom, 8'($urandom));
    else issue_command(CMD_CONTROL, $urandom, 8'($urandom));
  endtask

  // Reset configuration: voltages at and beyond the limits, clear frames with
  // all and no data bits set, the control word and pivot loads at both ends.
  task automatic test_reset_defaults();
    program_settings(default_settings());
    issue_command(CMD_WRITE, 32'h0000_0000, 8'h00);
    issue_command(CMD_WRITE, 32'(10 * VOLT), 8'hFF);
    issue_command(CMD_WRITE, -32'(10 * VOLT), 8'h00);
    issue_command(CMD_WRITE, 32'h7FFF_FFFF, 8'h00);
    issue_command(CMD_WRITE, 32'h8000_0000, 8'h00);
    issue_command(CMD_WRITE, 32'h0000_0001, 8'h00);
    issue_command(CMD_WRITE, 32'hFFFF_FFFF, 8'h00);
    issue_command(CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF);
    issue_command(CMD_CLEAR, 32'h0000_0000, 8'h00);
    issue_command(CMD_CONTROL, 32'h0000_0000, 8'h00);
    issue_command(CMD_PIVOT, 32'h7FFF_FFFF, 8'hFF);
    issue_command(CMD_PIVOT, 32'h8000_0000, 8'h00);
  endtask

  // Inverting the most negative code, crossed limits, a pivot count below
  // and above its range, a falling segment and both ends of the pivot range.
  task automatic test_edge_cases();
    dac_settings_t s;
    s        = default_settings();
    s.rng    = RANGE_UNI5;
    s.invert = 1'b1;
    s.lim_lo = 32'h8000_0000;
    s.lim_hi = 32'h7FFF_FFFF;
    program_settings(s);
    issue_command(CMD_WRITE, 32'h8000_0000, 8'h00);
    issue_command(CMD_WRITE, 32'h7FFF_FFFF, 8'h00);
    issue_command(CMD_CONTROL, 32'h0000_0000, 8'h00);

    s        = default_settings();
    s.rng    = RANGE_UNI10;
    s.lim_lo = 32'(3 * VOLT);
    s.lim_hi = -32'(3 * VOLT);
    program_settings(s);
    issue_command(CMD_WRITE, 32'h0000_0000, 8'h00);
    issue_command(CMD_WRITE, 32'h8000_0000, 8'h00);
    issue_command(CMD_CONTROL, 32'h0000_0000, 8'h00);

    s           = default_settings();
    s.rng       = RANGE_BI5;
    s.cal_en    = 1'b1;
    s.cal_min   = -32'(VOLT);
    s.cal_scale = 32'h0001_0000;
    s.pivots    = 9'd0;
    program_settings(s);
    issue_command(CMD_PIVOT, 32'(2 * VOLT), 8'h00);
    issue_command(CMD_PIVOT, -32'(3 * VOLT) + 32'd1, 8'h01);
    issue_command(CMD_WRITE, -32'(5 * VOLT), 8'h00);
    issue_command(CMD_WRITE, 32'h004C_CCCD, 8'h00);
    issue_command(CMD_WRITE, 32'(9 * VOLT), 8'h00);

    s.cal_scale = 32'hFFFF_FFFF;
    s.pivots    = 9'h1FF;
    program_settings(s);
    issue_command(CMD_WRITE, 32'(10 * VOLT), 8'h00);
    issue_command(CMD_WRITE, -32'(VOLT), 8'h00);
  endtask

  // Random commands under several random settings, with the sender idling
  // for the given share of cycles.
  task automatic test_random_traffic(int idle_pct, int n_settings, int n_items);
    sender_idle_pct = idle_pct;
    repeat (n_settings) begin
      program_settings(random_settings());
      repeat (n_items) random_command();
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Result side. The block cannot be stalled, so every strobe is a
  // transaction and is matched against the oldest predicted frame.
  always @(posedge clk_i) begin
    dac_result_t want;
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (pending_frames.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, frame %h", $time, frame_o);
      end else begin
        want = pending_frames.pop_front();
        compare_field("frame", 32'(want.frame), 32'(frame_o));
        compare_field("clamped_voltage", want.clamped, clamped_voltage_o);
        compare_field("code_saturated", 32'(want.saturated), 32'(code_saturated_o));
      end
    end
  end

  // Watchdog: any command, result or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    command_i     <= CMD_PIVOT;
    value_i       <= '0;
    pivot_index_i <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_edge_cases();
    test_random_traffic(17, 3, 44);
    test_random_traffic(57, 3, 44);
    test_random_traffic(0, 3, 44);
    settle_pipeline();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ dac_calibrated_output_framer.f @@
design/dcof_pkg.sv
design/dcof_front.sv
design/dcof_pivot_stage.sv
design/dcof_interp.sv
design/dcof_scale.sv
design/dac_calibrated_output_framer.sv
test/tb_top.sv
